### rtl/ds_belief_plausibility_engine_assert.svh
// assertion macros shared by the belief / plausibility engine rtl
`ifndef DS_BELIEF_PLAUSIBILITY_ENGINE_ASSERT_SVH
`define DS_BELIEF_PLAUSIBILITY_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DSBP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsbp assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DSBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsbp assertion failed");

`endif

### rtl/dsbp_pkg.sv
// shared widths, codes and types of the belief / plausibility engine
`default_nettype none
package dsbp_pkg;

  localparam int KIND_W   = 2;
  localparam int IDX_W    = 10;
  localparam int MASS_W   = 16;
  localparam int SUM_W    = 26;
  localparam int RATIO_W  = 17;
  localparam int NS_W     = 4;

  localparam int DEF_MAX_SINGLETONS = 10;
  localparam int DEF_MASS_BITS      = 16;

  localparam logic [NS_W-1:0] NS_RESET = 4'd10;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PLS   = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### rtl/dsbp_in_if.sv
// input channel interface: write / query transactions
`default_nettype none
interface dsbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [dsbp_pkg::KIND_W-1:0]   kind;
  logic [dsbp_pkg::IDX_W-1:0]    subset_index;
  logic [dsbp_pkg::MASS_W-1:0]   mass_value;

  modport source (output valid, output kind, output subset_index, output mass_value,
                  input ready);
  modport sink (input valid, input kind, input subset_index, input mass_value,
                output ready);
endinterface
`default_nettype wire

### rtl/dsbp_out_if.sv
// result channel interface: query results
`default_nettype none
interface dsbp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          query_type;
  logic [dsbp_pkg::SUM_W-1:0]    raw_sum;
  logic [dsbp_pkg::SUM_W-1:0]    mass_total;
  logic [dsbp_pkg::RATIO_W-1:0]  ratio_q16;
  logic                          total_zero;

  modport source (output valid, output query_type, output raw_sum, output mass_total,
                  output ratio_q16, output total_zero, input ready);
  modport sink (input valid, input query_type, input raw_sum, input mass_total,
                input ratio_q16, input total_zero, output ready);
endinterface
`default_nettype wire

### rtl/dsbp_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none
module dsbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/dsbp_div.sv
// radix-2 ratio unit: floor(dividend * 2^16 / divisor) for dividend <= divisor
`default_nettype none
module dsbp_div #(
  parameter int W = 26
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [W-1:0]                     dividend,
  input  logic [W-1:0]                     divisor,
  output dsbp_pkg::div_stat_t              stat,
  output logic [dsbp_pkg::RATIO_W-1:0]     quotient
);

  localparam int QW = dsbp_pkg::RATIO_W;
  localparam int CW = $clog2(QW);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          first_r, first_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    // first step takes the dividend unshifted, it gives the integer bit
    trial = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});

    busy_nxt  = busy_r;
    done_nxt  = done_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    q_nxt     = q_r;

    if (start) begin
      dvs_nxt   = divisor;
      rem_nxt   = dividend;
      q_nxt     = '0;
      first_nxt = 1'b1;
      cnt_nxt   = '0;
      // zero total: ratio forced to zero at once
      busy_nxt  = (divisor != '0);
      done_nxt  = (divisor == '0);
    end else if (busy_r) begin
      rem_nxt   = ge ? W'(diff) : W'(trial);
      q_nxt     = {q_r[QW-2:0], ge};
      first_nxt = 1'b0;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule
`default_nettype wire

### rtl/ds_belief_plausibility_engine.sv
// top level of the dempster-shafer belief / plausibility engine
// usage:
// - in_ch carries transactions of three kinds: mass write, belief query and
//   plausibility query; a transaction is taken when valid and ready are high
// - out_ch carries one result per query (none for a write): raw sum, mass
//   total, q16 ratio and a zero-total flag
// - cfg_we / cfg_wdata write the frame size (singletons in use)
// - after reset the mass table memory is cleared by a pass of one entry per
//   cycle over all 2^MAX_SINGLETONS entries (1024 by default); in_ch.ready
//   stays low for the whole pass, config writes are taken throughout
// - a write reads the old mass, then writes the new mass and updates the total
//   through the single table memory port pair
// - a query walks all subsets of its mask within the frame, one table read
//   per cycle, then runs the ratio unit and hands the result over to the
//   output register
// - one transaction is worked on at a time; a finished result waits in the
//   output register, so the next transaction is taken while the receiver
//   stalls, and a later query only holds at its end until the slot is free
`default_nettype none
module ds_belief_plausibility_engine #(
  parameter int MAX_SINGLETONS = dsbp_pkg::DEF_MAX_SINGLETONS,
  parameter int MASS_BITS      = dsbp_pkg::DEF_MASS_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [dsbp_pkg::NS_W-1:0]  cfg_wdata,
  dsbp_in_if.sink                    in_ch,
  dsbp_out_if.source                 out_ch
);

`include "ds_belief_plausibility_engine_assert.svh"

  localparam int AW    = MAX_SINGLETONS;
  localparam int DEPTH = 1 << AW;
  // total of all entries never exceeds DEPTH * (2^MASS_BITS - 1)
  localparam int ACC_W = MASS_BITS + AW;
  localparam int NW    = $clog2(MAX_SINGLETONS + 1);

  // controller states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [dsbp_pkg::NS_W-1:0]      cfg_r;
  logic [AW-1:0]                  clr_addr_r, clr_addr_nxt;
  logic [ACC_W-1:0]               sum_r, sum_nxt;
  logic [AW-1:0]                  m_r, m_nxt;
  logic [AW-1:0]                  s_r, s_nxt;
  logic                           pend_r, pend_nxt;
  logic [ACC_W-1:0]               acc_r, acc_nxt;
  logic                           qt_r, qt_nxt;
  logic [AW-1:0]                  widx_r, widx_nxt;
  logic [MASS_BITS-1:0]           wval_r, wval_nxt;
  logic [ACC_W-1:0]               raw_r, raw_nxt;
  logic [ACC_W-1:0]               raw_c;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_qt_r;
  logic [dsbp_pkg::SUM_W-1:0]     out_raw_r;
  logic [dsbp_pkg::SUM_W-1:0]     out_total_r;
  logic [dsbp_pkg::RATIO_W-1:0]   out_ratio_r;
  logic                           out_tz_r;
  logic                           out_load;
  logic                           slot_free;

  logic [NW-1:0]                  n_eff;
  logic [AW-1:0]                  fmask;
  logic [AW-1:0]                  in_idx;
  logic                           in_ready;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [MASS_BITS-1:0]           ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [MASS_BITS-1:0]           ram_rdata;

  logic                           div_start;
  dsbp_pkg::div_stat_t            div_stat;
  logic [dsbp_pkg::RATIO_W-1:0]   div_q;

  // mass table
  dsbp_ram #(
    .WIDTH (MASS_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ratio unit, operands taken in the cycle the walk ends
  dsbp_div #(
    .W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (raw_c),
    .divisor  (sum_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // frame size clamp: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    priority if (cfg_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(cfg_r) > MAX_SINGLETONS) begin
      n_eff = NW'(MAX_SINGLETONS);
    end else begin
      n_eff = NW'(cfg_r);
    end
    for (int i = 0; i < AW; i++) begin
      fmask[i] = (i < int'(n_eff));
    end
  end

  assign in_idx    = AW'(in_ch.subset_index);
  assign slot_free = !out_valid_r || out_ch.ready;

  // plausibility is the total minus the mass inside the complement
  always_comb begin
    if (qt_r) begin
      raw_c = (acc_r <= sum_r) ? (sum_r - acc_r) : '0;
    end else begin
      raw_c = acc_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    sum_nxt      = sum_r;
    m_nxt        = m_r;
    s_nxt        = s_r;
    pend_nxt     = 1'b0;
    acc_nxt      = acc_r;
    qt_nxt       = qt_r;
    widx_nxt     = widx_r;
    wval_nxt     = wval_r;
    raw_nxt      = raw_r;
    ram_we       = 1'b0;
    ram_waddr    = widx_r;
    ram_wdata    = wval_r;
    ram_raddr    = s_r;
    div_start    = 1'b0;
    out_load     = 1'b0;
    in_ready     = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        // read the addressed entry right away, a write needs the old mass
        ram_raddr = in_idx;
        if (in_ch.valid) begin
          unique case (in_ch.kind)
            dsbp_pkg::KIND_WRITE: begin
              widx_nxt  = in_idx;
              // the empty set always holds zero
              wval_nxt  = (in_idx == '0) ? '0 : MASS_BITS'(in_ch.mass_value);
              state_nxt = ST_WRITE;
            end
            dsbp_pkg::KIND_BEL: begin
              m_nxt     = in_idx & fmask;
              s_nxt     = in_idx & fmask;
              acc_nxt   = '0;
              qt_nxt    = 1'b0;
              state_nxt = ST_WALK;
            end
            dsbp_pkg::KIND_PLS: begin
              m_nxt     = ~in_idx & fmask;
              s_nxt     = ~in_idx & fmask;
              acc_nxt   = '0;
              qt_nxt    = 1'b1;
              state_nxt = ST_WALK;
            end
            default: begin
              // unused kind: dropped without a result
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        sum_nxt   = sum_r - ACC_W'(ram_rdata) + ACC_W'(wval_r);
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        // read data is registered, so it arrives in the cycle after its address
        if (pend_r) begin
          acc_nxt = acc_r + ACC_W'(ram_rdata);
        end
        if (s_r != '0) begin
          // next lower subset of the mask
          pend_nxt = 1'b1;
          s_nxt    = (s_r - 1'b1) & m_r;
        end else if (!pend_r) begin
          raw_nxt   = raw_c;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      sum_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      sum_r       <= sum_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame size register, written at any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= dsbp_pkg::NS_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    s_r    <= s_nxt;
    acc_r  <= acc_nxt;
    qt_r   <= qt_nxt;
    widx_r <= widx_nxt;
    wval_r <= wval_nxt;
    raw_r  <= raw_nxt;
    if (out_load) begin
      out_qt_r    <= qt_r;
      out_raw_r   <= dsbp_pkg::SUM_W'(raw_r);
      out_total_r <= dsbp_pkg::SUM_W'(sum_r);
      out_ratio_r <= div_q;
      out_tz_r    <= (sum_r == '0);
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.query_type = out_qt_r;
  assign out_ch.raw_sum    = out_raw_r;
  assign out_ch.mass_total = out_total_r;
  assign out_ch.ratio_q16  = out_ratio_r;
  assign out_ch.total_zero = out_tz_r;

  // no transaction taken while the table is being cleared
  `DSBP_ASSERT_IMPL(a_clear_blocks_input, state_r == ST_CLEAR, !in_ch.ready)
  // a partial subset sum never exceeds the running total
  `DSBP_ASSERT_IMPL(a_walk_within_total, state_r == ST_WALK, acc_r <= sum_r)
  // ratio never above one
  `DSBP_ASSERT_IMPL(a_ratio_range, out_valid_r, out_ratio_r <= dsbp_pkg::RATIO_ONE)
  // zero total forces zero sum and zero ratio
  `DSBP_ASSERT_IMPL(a_zero_total, out_valid_r && out_tz_r,
                    (out_ratio_r == '0) && (out_raw_r == '0))
  // an accepted write goes to the write-back cycle
  `DSBP_ASSERT_NEXT(a_write_backs, in_ch.valid && in_ready && (in_ch.kind == dsbp_pkg::KIND_WRITE),
                    state_r == ST_WRITE)

endmodule
`default_nettype wire
